@@ hdl/kufe_pkg.sv @@
// Shared types and constants for the union-find edge filter.
// Used by kufe_forest and the top level; kufe_ram stands alone.
package kufe_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = VERT_W + 1;
    localparam int WEIGHT_W     = 16;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(MAX_VERTICES);

    // result status codes
    localparam logic [1:0] STATUS_ACCEPT = 2'd0;
    localparam logic [1:0] STATUS_CYCLE  = 2'd1;
    localparam logic [1:0] STATUS_IGNORE = 2'd2;
    localparam logic [1:0] STATUS_RANGE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_WALK_B,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                       new_graph;
        logic [VERT_W-1:0]          vertex_a;
        logic [VERT_W-1:0]          vertex_b;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       last_edge;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [VERT_W-1:0]          low_vertex;
        logic [VERT_W-1:0]          high_vertex;
        logic signed [WEIGHT_W-1:0] out_weight;
        logic                       tree_done;
    } out_item_t;

    // link request from the sequencer to the forest
    typedef struct packed {
        logic              en;
        logic [VERT_W-1:0] child;
        logic [VERT_W-1:0] parent;
    } link_t;

endpackage

@@ hdl/kufe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/kufe_forest.sv @@
// Union-find forest: parent RAM plus one valid flop per vertex.
// Depends on kufe_pkg and kufe_ram.
module kufe_forest (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic [kufe_pkg::VERT_W-1:0]   look_addr,
    input  kufe_pkg::link_t               link,
    output logic                          found_valid,
    output logic [kufe_pkg::VERT_W-1:0]   found_parent
);

    logic [kufe_pkg::MAX_VERTICES-1:0] valid_reg;
    logic [kufe_pkg::VERT_W-1:0]       addr_reg;

    // parent pointers; an entry is only trusted once its valid bit is set
    kufe_ram #(
        .WIDTH (kufe_pkg::VERT_W),
        .DEPTH (kufe_pkg::MAX_VERTICES)
    ) u_parent (
        .clk   (clk),
        .we    (link.en),
        .waddr (link.child),
        .wdata (link.parent),
        .raddr (look_addr),
        .rdata (found_parent)
    );

    // clear all on a new graph, mark a child once linked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (link.en)
        begin
            valid_reg[link.child] <= 1'b1;
        end
    end

    // track the address whose parent is in the RAM output register
    always_ff @(posedge clk)
    begin
        addr_reg <= look_addr;
    end

    assign found_valid = valid_reg[addr_reg];

endmodule

@@ hdl/kruskal_union_find_edge_filter_unit.sv @@
// From accept to out_valid an edge passes through the check state, walk a, walk b and the result
// state; one walk step per cycle through the single parent RAM read port.
// One item at a time: the next edge is accepted no earlier than the cycle after its result is
// loaded, and the result state waits while the output register is stalled.
// Out-of-range and ignored edges skip both walks. Reset (rst_n, async low) clears valid bits,
// accepted count, and sets vertex count to 256; the parent RAM is not cleared.
module kruskal_union_find_edge_filter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kufe_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kufe_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kufe_pkg::out_item_t            out_data
);

    kufe_pkg::state_t               state_reg, state_next;
    kufe_pkg::in_item_t             item_reg, item_next;
    kufe_pkg::out_item_t            out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    logic [kufe_pkg::VERT_W-1:0]    cur_reg, cur_next;
    logic [kufe_pkg::VERT_W-1:0]    root_a_reg, root_a_next;
    logic [1:0]                     status_reg, status_next;
    logic [kufe_pkg::COUNT_W-1:0]   acc_count_reg, acc_count_next;
    logic [kufe_pkg::COUNT_W-1:0]   vcount_reg;
    logic [kufe_pkg::COUNT_W-1:0]   count_eff;
    logic [kufe_pkg::COUNT_W-1:0]   limit;
    logic                           clear;
    kufe_pkg::link_t                link;
    logic                           found_valid;
    logic [kufe_pkg::VERT_W-1:0]    found_parent;
    logic                           root_hit;
    logic                           a_lt_b;

    // clamp vertex count to 1..MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            count_eff = kufe_pkg::COUNT_W'(1);
        end
        else if (vcount_reg > kufe_pkg::VCOUNT_RESET)
        begin
            count_eff = kufe_pkg::VCOUNT_RESET;
        end
        else
        begin
            count_eff = vcount_reg;
        end
    end

    assign limit     = count_eff - kufe_pkg::COUNT_W'(1);
    assign cfg_ready = 1'b1;
    assign root_hit  = !found_valid || (found_parent == cur_reg);
    assign a_lt_b    = item_reg.vertex_a < item_reg.vertex_b;

    kufe_forest u_forest (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (clear),
        .look_addr    (cur_next),
        .link         (link),
        .found_valid  (found_valid),
        .found_parent (found_parent)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= kufe_pkg::VCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kufe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_count_reg <= acc_count_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        out_reg    <= out_next;
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        status_reg <= status_next;
    end

    // sequencer: check, walk a, walk b, link, result
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cur_next       = cur_reg;
        root_a_next    = root_a_reg;
        status_next    = status_reg;
        acc_count_next = acc_count_reg;
        clear          = 1'b0;
        link           = '0;
        in_ready       = 1'b0;

        unique case (state_reg)
            kufe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = kufe_pkg::ST_CHECK;
                    if (in_data.new_graph)
                    begin
                        clear          = 1'b1;
                        acc_count_next = '0;
                    end
                end
            end

            kufe_pkg::ST_CHECK:
            begin
                if (acc_count_reg >= limit)
                begin
                    status_next = kufe_pkg::STATUS_IGNORE;
                    state_next  = kufe_pkg::ST_RESULT;
                end
                else if ({1'b0, item_reg.vertex_a} >= count_eff ||
                         {1'b0, item_reg.vertex_b} >= count_eff)
                begin
                    status_next = kufe_pkg::STATUS_RANGE;
                    state_next  = kufe_pkg::ST_RESULT;
                end
                else
                begin
                    cur_next   = item_reg.vertex_a;
                    state_next = kufe_pkg::ST_WALK_A;
                end
            end

            kufe_pkg::ST_WALK_A:
            begin
                if (root_hit)
                begin
                    root_a_next = cur_reg;
                    cur_next    = item_reg.vertex_b;
                    state_next  = kufe_pkg::ST_WALK_B;
                end
                else
                begin
                    cur_next = found_parent;
                end
            end

            kufe_pkg::ST_WALK_B:
            begin
                if (root_hit)
                begin
                    state_next = kufe_pkg::ST_RESULT;
                    if (cur_reg == root_a_reg)
                    begin
                        status_next = kufe_pkg::STATUS_CYCLE;
                    end
                    else
                    begin
                        // link the larger root under the smaller one
                        link.en        = 1'b1;
                        link.child     = (cur_reg > root_a_reg) ? cur_reg : root_a_reg;
                        link.parent    = (cur_reg > root_a_reg) ? root_a_reg : cur_reg;
                        acc_count_next = acc_count_reg + kufe_pkg::COUNT_W'(1);
                        status_next    = kufe_pkg::STATUS_ACCEPT;
                    end
                end
                else
                begin
                    cur_next = found_parent;
                end
            end

            kufe_pkg::ST_RESULT:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status      = status_reg;
                    out_next.low_vertex  = a_lt_b ? item_reg.vertex_a : item_reg.vertex_b;
                    out_next.high_vertex = a_lt_b ? item_reg.vertex_b : item_reg.vertex_a;
                    out_next.out_weight  = item_reg.edge_weight;
                    out_next.tree_done   = (acc_count_reg >= limit) || item_reg.last_edge;
                    out_valid_next       = 1'b1;
                    state_next           = kufe_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kufe_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a link always points a larger root at a smaller one
    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        link.en |-> (link.child > link.parent))
        else $error("link does not point to a smaller root");

    // parents seen during a walk are never above the vertex walked
    a_walk_down: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kufe_pkg::ST_WALK_A || state_reg == kufe_pkg::ST_WALK_B)
         && found_valid) |-> (found_parent <= cur_reg))
        else $error("parent pointer climbs during root walk");

    // a new graph restarts the accepted count
    a_new_graph: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.new_graph) |=> (acc_count_reg == '0))
        else $error("accepted count not cleared on new graph");

    // each link bumps the accepted count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        link.en |=> (acc_count_reg == $past(acc_count_reg) + kufe_pkg::COUNT_W'(1)))
        else $error("accepted count out of step with links");

    // a result is only loaded over an empty or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kufe_pkg::ST_RESULT && out_valid_reg && !out_ready)
        |=> (state_reg == kufe_pkg::ST_RESULT))
        else $error("result left the sequencer while output was stalled");

endmodule

@@ test/kufe_checker.sv @@
// Scoreboard for the union-find edge filter: tracks the vertex-count register,
// keeps its own forest and tree-edge count, and checks every result beat.
// Depends on kufe_pkg for the payload types and status codes.
module kufe_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [kufe_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  kufe_pkg::in_item_t           in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  kufe_pkg::out_item_t          out_data,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow forest and tree progress
    logic [kufe_pkg::VERT_W-1:0]  forest_parent [kufe_pkg::MAX_VERTICES];
    bit                           forest_linked [kufe_pkg::MAX_VERTICES];
    int                           tree_edges;
    logic [kufe_pkg::COUNT_W-1:0] vcount;
    kufe_pkg::out_item_t          verdict_q [$];
    int                           mismatches = 0;

    // follow parent links up to the root, bounded at MAX_VERTICES steps
    function automatic logic [kufe_pkg::VERT_W-1:0] root_of(
        logic [kufe_pkg::VERT_W-1:0] v);
        logic [kufe_pkg::VERT_W-1:0] cur;
        int                          steps;
        cur   = v;
        steps = 0;
        while (forest_linked[cur] && forest_parent[cur] != cur &&
               steps < kufe_pkg::MAX_VERTICES)
        begin
            cur = forest_parent[cur];
            steps++;
        end
        return cur;
    endfunction

    // classify one edge and update the forest the way the block should
    function automatic kufe_pkg::out_item_t judge_edge(kufe_pkg::in_item_t e);
        kufe_pkg::out_item_t         r;
        int                          span;
        int                          lim;
        logic [kufe_pkg::VERT_W-1:0] ra;
        logic [kufe_pkg::VERT_W-1:0] rb;
        span = (vcount == 0) ? 1 :
               ((vcount > kufe_pkg::MAX_VERTICES) ? kufe_pkg::MAX_VERTICES : int'(vcount));
        lim  = span - 1;
        if (e.new_graph)
        begin
            foreach (forest_linked[i])
                forest_linked[i] = 1'b0;
            tree_edges = 0;
        end
        r.low_vertex  = (e.vertex_a < e.vertex_b) ? e.vertex_a : e.vertex_b;
        r.high_vertex = (e.vertex_a < e.vertex_b) ? e.vertex_b : e.vertex_a;
        r.out_weight  = e.edge_weight;
        if (tree_edges >= lim)
        begin
            r.status = kufe_pkg::STATUS_IGNORE;
        end
        else if (int'(e.vertex_a) >= span || int'(e.vertex_b) >= span)
        begin
            r.status = kufe_pkg::STATUS_RANGE;
        end
        else
        begin
            ra = root_of(e.vertex_a);
            rb = root_of(e.vertex_b);
            if (ra == rb)
            begin
                r.status = kufe_pkg::STATUS_CYCLE;
            end
            else
            begin
                // hang the larger root under the smaller one
                if (ra < rb)
                begin
                    forest_parent[rb] = ra;
                    forest_linked[rb] = 1'b1;
                end
                else
                begin
                    forest_parent[ra] = rb;
                    forest_linked[ra] = 1'b1;
                end
                tree_edges++;
                r.status = kufe_pkg::STATUS_ACCEPT;
            end
        end
        r.tree_done = (tree_edges >= lim) || e.last_edge;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare result beats first, then register and input beats of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        kufe_pkg::out_item_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            foreach (forest_linked[i])
                forest_linked[i] = 1'b0;
            tree_edges = 0;
            vcount     = kufe_pkg::VCOUNT_RESET;
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, got %p", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("low_vertex", want.low_vertex, out_data.low_vertex);
                    check_field("high_vertex", want.high_vertex, out_data.high_vertex);
                    check_field("out_weight", want.out_weight, out_data.out_weight);
                    check_field("tree_done", want.tree_done, out_data.tree_done);
                end
            end
            if (cfg_valid && cfg_ready)
                vcount = cfg_data;
            if (in_valid && in_ready)
                verdict_q.push_back(judge_edge(in_data));
            pending    <= verdict_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ test/tb.sv @@
// Top of the edge filter regression: clock, reset, edge stimulus, receiver stalls
// and the verdict. Depends on kufe_pkg, kufe_checker and the filter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int RX_HOLD    = 400;
    localparam int PHASE_VC [14] = '{16, 2, 1, 40, 0, 256, 8, 511, 3, 100, 255, 300, 24, 5};

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [kufe_pkg::COUNT_W-1:0] cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    kufe_pkg::in_item_t           in_data;
    logic                         out_valid;
    logic                         out_ready;
    kufe_pkg::out_item_t          out_data;
    int                           fail_count;
    int                           pending;

    int burst_left = 0;
    int items_sent = 0;
    int cur_vc     = kufe_pkg::MAX_VERTICES;
    bit hold_req   = 1'b0;

    kruskal_union_find_edge_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    kufe_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_of(int v);
        return (v == 0) ? 1 : ((v > kufe_pkg::MAX_VERTICES) ? kufe_pkg::MAX_VERTICES : v);
    endfunction

    function automatic kufe_pkg::in_item_t make_edge(bit ng, int a, int b, int w, bit last);
        kufe_pkg::in_item_t e;
        e.new_graph   = ng;
        e.vertex_a    = kufe_pkg::VERT_W'(a);
        e.vertex_b    = kufe_pkg::VERT_W'(b);
        e.edge_weight = kufe_pkg::WEIGHT_W'(w);
        e.last_edge   = last;
        return e;
    endfunction

    // offer one edge beat, opening a new burst after a random gap when needed
    task automatic send_edge(input kufe_pkg::in_item_t e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= e;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic finish_phase;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_vcount(input int v);
        cfg_valid <= 1'b1;
        cfg_data  <= kufe_pkg::COUNT_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_vc = v;
    endtask

    // one sorted edge list: growth edges extend the tree, the rest make cycles,
    // self loops, out-of-range endpoints and plain noise
    task automatic send_graph(input int span, input int n_edges, input int grow_pct);
        int                 eff;
        int                 fresh;
        int                 pick;
        int                 a;
        int                 b;
        int                 t;
        int                 wt;
        bit                 ng;
        kufe_pkg::in_item_t e;
        eff   = eff_of(cur_vc);
        fresh = 1;
        wt    = $urandom_range(0, 60000) - 32768;
        for (int k = 0; k < n_edges; k++)
        begin
            pick = $urandom_range(0, 99);
            ng   = (k == 0) || ($urandom_range(0, 199) == 0);
            if (ng)
                fresh = 1;
            wt = wt + $urandom_range(0, 150);
            if (wt > 32767)
                wt = 32767;
            if (pick < grow_pct && fresh < span)
            begin
                a = fresh;
                b = $urandom_range(0, fresh - 1);
                fresh++;
            end
            else if (pick < 90)
            begin
                a = $urandom_range(0, span - 1);
                b = $urandom_range(0, span - 1);
            end
            else if (pick < 96)
            begin
                a = $urandom_range(0, span - 1);
                b = (eff < kufe_pkg::MAX_VERTICES) ? $urandom_range(eff, 255)
                                                   : $urandom_range(0, 255);
            end
            else
            begin
                a  = $urandom_range(0, 255);
                b  = $urandom_range(0, 255);
                wt = $urandom_range(0, 65535) - 32768;
            end
            if ($urandom_range(0, 1))
            begin
                t = a;
                a = b;
                b = t;
            end
            e = make_edge(ng, a, b, wt, (k == n_edges - 1) || ($urandom_range(0, 49) == 0));
            send_edge(e);
        end
    endtask

    // receiver: change stall pattern every so often, and honor a long hold-off request
    initial
    begin
        int mode;
        int stretch;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            for (int k = 0; k < stretch; k++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    out_ready <= 1'b0;
                    for (int h = 1; h < RX_HOLD; h++)
                        @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= (k % 4 == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // watchdog: end the run when no beat moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int span;
        int eff;
        int quota;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset vertex count: extreme weights, cycle, self loop, last-edge flag
        send_edge(make_edge(1, 0, 255, -32768, 0));
        send_edge(make_edge(0, 255, 0, 32767, 0));
        send_edge(make_edge(0, 7, 7, -1, 0));
        send_edge(make_edge(0, 255, 254, 0, 0));
        send_edge(make_edge(0, 1, 2, 1, 1));
        finish_phase();

        // four vertices: out of range, fill the tree, ignore once complete
        write_vcount(4);
        send_edge(make_edge(1, 0, 5, -100, 0));
        send_edge(make_edge(0, 4, 1, -50, 0));
        send_edge(make_edge(0, 3, 2, 0, 0));
        send_edge(make_edge(0, 1, 0, 10, 0));
        send_edge(make_edge(0, 2, 1, 20, 0));
        send_edge(make_edge(0, 0, 3, 30, 0));
        send_edge(make_edge(0, 9, 200, 40, 0));
        send_edge(make_edge(1, 3, 0, 50, 1));
        finish_phase();

        // a single vertex: every edge is ignored
        write_vcount(1);
        send_edge(make_edge(1, 0, 0, 0, 0));
        send_edge(make_edge(0, 255, 255, 32767, 1));
        finish_phase();

        // random phases over a range of vertex counts
        foreach (PHASE_VC[p])
        begin
            write_vcount(PHASE_VC[p]);
            eff = eff_of(cur_vc);
            if (cur_vc == kufe_pkg::MAX_VERTICES)
            begin
                // full-size tree, with a long receiver hold-off while edges keep coming
                hold_req = 1'b1;
                send_graph(kufe_pkg::MAX_VERTICES, 300, 90);
            end
            else
            begin
                quota = items_sent + 35;
                while (items_sent < quota)
                begin
                    span = (eff <= 40) ? eff : $urandom_range(4, 30);
                    send_graph(span, $urandom_range(span, 2 * span + 4), 40);
                end
            end
            finish_phase();
        end

        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/kufe_pkg.sv
hdl/kufe_ram.sv
hdl/kufe_forest.sv
hdl/kruskal_union_find_edge_filter_unit.sv
test/kufe_checker.sv
test/tb.sv
